FILE: sv/afbg_pkg.sv
package afbg_pkg;

    // Field and datapath widths.
    localparam int unsigned StepW   = 16;
    localparam int unsigned OriginW = 28;
    localparam int unsigned PixW    = 8;
    localparam int unsigned ProdW   = StepW + PixW + 1;
    localparam int unsigned SumW    = 30;
    localparam int unsigned FracW   = 8;
    localparam int unsigned TexW    = SumW - FracW;
    localparam int unsigned CoordW  = 10;
    localparam int unsigned IndexW  = 14;
    localparam int unsigned RegIdxW = 8;
    localparam int unsigned CfgW    = 28;

    typedef enum logic [RegIdxW-1:0] {
        REG_STEP_X_COL  = 8'd0,
        REG_STEP_X_LINE = 8'd1,
        REG_STEP_Y_COL  = 8'd2,
        REG_STEP_Y_LINE = 8'd3,
        REG_ORIGIN_X    = 8'd4,
        REG_ORIGIN_Y    = 8'd5,
        REG_SIZE_SEL    = 8'd6,
        REG_WRAP_EN     = 8'd7
    } t_reg_idx;

    localparam logic signed [StepW-1:0]   RstStepXCol  = 16'sd256;
    localparam logic signed [StepW-1:0]   RstStepXLine = 16'sd0;
    localparam logic signed [StepW-1:0]   RstStepYCol  = 16'sd0;
    localparam logic signed [StepW-1:0]   RstStepYLine = 16'sd256;
    localparam logic signed [OriginW-1:0] RstOrigin    = 28'sd0;

    typedef struct packed {
        logic signed [StepW-1:0]   step_x_col;
        logic signed [StepW-1:0]   step_x_line;
        logic signed [StepW-1:0]   step_y_col;
        logic signed [StepW-1:0]   step_y_line;
        logic signed [OriginW-1:0] origin_x;
        logic signed [OriginW-1:0] origin_y;
        logic [1:0]                size_sel;
        logic                      wrap_en;
    } t_cfg;

    // Products after the first stage.
    typedef struct packed {
        logic                    off_screen;
        logic signed [ProdW-1:0] px_line;
        logic signed [ProdW-1:0] px_col;
        logic signed [ProdW-1:0] py_line;
        logic signed [ProdW-1:0] py_col;
    } t_prod;

    // Integer texel coordinates after the second stage.
    typedef struct packed {
        logic                   off_screen;
        logic signed [TexW-1:0] tx;
        logic signed [TexW-1:0] ty;
    } t_texel;

    typedef struct packed {
        logic              transparent;
        logic [IndexW-1:0] map_index;
        logic [2:0]        texel_col;
        logic [2:0]        texel_row;
    } t_result;

    // Pipeline advance enables, one per stage.
    typedef struct packed {
        logic adv_mul;
        logic adv_sum;
        logic adv_addr;
    } t_pipe_ctl;

endpackage

FILE: sv/afbg_if.sv
interface afbg_pix_if;
    import afbg_pkg::*;
    logic            valid;
    logic            ready;
    logic [PixW-1:0] scan_line;
    logic [PixW-1:0] column;

    modport source (output valid, output scan_line, output column, input ready);
    modport sink (input valid, input scan_line, input column, output ready);
endinterface

interface afbg_tex_if;
    import afbg_pkg::*;
    logic              valid;
    logic              ready;
    logic              transparent;
    logic [IndexW-1:0] map_index;
    logic [2:0]        texel_col;
    logic [2:0]        texel_row;

    modport source (output valid, output transparent, output map_index,
                    output texel_col, output texel_row, input ready);
    modport sink (input valid, input transparent, input map_index,
                  input texel_col, input texel_row, output ready);
endinterface

interface afbg_cfg_if;
    import afbg_pkg::*;
    logic               valid;
    logic               ready;
    logic [RegIdxW-1:0] index;
    logic [CfgW-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/afbg_mul_stage.sv
module afbg_mul_stage
    import afbg_pkg::*;
#(
    parameter int SCREEN_WIDTH = 240
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [PixW-1:0] i_scan_line,
    input  logic [PixW-1:0] i_column,
    input  t_cfg            i_cfg,
    output logic            o_valid,
    output t_prod           o_prod
);

    logic                    r_valid;
    t_prod                   r_prod;
    t_prod                   n_prod;
    logic signed [ProdW-1:0] line_s;
    logic signed [ProdW-1:0] col_s;

    // Both factors are held at the full product width, so each multiply is
    // signed and keeps every bit of the result.
    always_comb begin
        line_s             = $signed(ProdW'(i_scan_line));
        col_s              = $signed(ProdW'(i_column));
        n_prod.off_screen  = (int'(i_column) >= SCREEN_WIDTH);
        n_prod.px_line     = line_s * i_cfg.step_x_line;
        n_prod.px_col      = col_s * i_cfg.step_x_col;
        n_prod.py_line     = line_s * i_cfg.step_y_line;
        n_prod.py_col      = col_s * i_cfg.step_y_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

FILE: sv/afbg_sum_stage.sv
module afbg_sum_stage
    import afbg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_valid,
    input  t_prod  i_prod,
    input  t_cfg   i_cfg,
    output logic   o_valid,
    output t_texel o_texel
);

    logic                   r_valid;
    t_texel                 r_texel;
    logic signed [SumW-1:0] sum_x;
    logic signed [SumW-1:0] sum_y;

    // Dropping the fraction bits of a signed sum is a floor toward minus infinity.
    always_comb begin
        sum_x = SumW'(i_cfg.origin_x) + SumW'(i_prod.px_line) + SumW'(i_prod.px_col);
        sum_y = SumW'(i_cfg.origin_y) + SumW'(i_prod.py_line) + SumW'(i_prod.py_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv && i_valid) begin
            r_texel.off_screen <= i_prod.off_screen;
            r_texel.tx         <= sum_x[SumW-1:FracW];
            r_texel.ty         <= sum_y[SumW-1:FracW];
        end
    end

    assign o_valid = r_valid;
    assign o_texel = r_texel;

endmodule

FILE: sv/afbg_addr_stage.sv
module afbg_addr_stage
    import afbg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  logic    i_valid,
    input  t_texel  i_texel,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    output t_result o_result
);

    logic              r_valid;
    t_result           r_result;
    t_result           n_result;
    logic [CoordW-1:0] side_mask;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              out_x;
    logic              out_y;
    logic [IndexW-1:0] row_part;

    always_comb begin
        unique case (i_cfg.size_sel)
            2'd0:    side_mask = 10'h07F;
            2'd1:    side_mask = 10'h0FF;
            2'd2:    side_mask = 10'h1FF;
            default: side_mask = 10'h3FF;
        endcase

        // A coordinate is inside the map when it is not negative and no bit
        // at or above the side length is set.
        out_x = (|i_texel.tx[TexW-1:CoordW]) || (|(i_texel.tx[CoordW-1:0] & ~side_mask));
        out_y = (|i_texel.ty[TexW-1:CoordW]) || (|(i_texel.ty[CoordW-1:0] & ~side_mask));

        // Wrapping keeps the low bits; inside the map this changes nothing.
        cx = i_texel.tx[CoordW-1:0] & side_mask;
        cy = i_texel.ty[CoordW-1:0] & side_mask;

        // Tiles per row is 16 shifted by the size select.
        unique case (i_cfg.size_sel)
            2'd0:    row_part = IndexW'(cy[CoordW-1:3]) << 4;
            2'd1:    row_part = IndexW'(cy[CoordW-1:3]) << 5;
            2'd2:    row_part = IndexW'(cy[CoordW-1:3]) << 6;
            default: row_part = IndexW'(cy[CoordW-1:3]) << 7;
        endcase

        if (i_texel.off_screen || ((out_x || out_y) && !i_cfg.wrap_en)) begin
            n_result.transparent = 1'b1;
            n_result.map_index   = '0;
            n_result.texel_col   = '0;
            n_result.texel_row   = '0;
        end else begin
            n_result.transparent = 1'b0;
            n_result.map_index   = row_part | IndexW'(cx[CoordW-1:3]);
            n_result.texel_col   = cx[2:0];
            n_result.texel_row   = cy[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: sv/affine_background_texel_address.sv
// Texel address generator for one rotated or scaled tile background.
// Pixel channel i_pix: each transfer carries a scanline and a screen column.
// Texel channel o_tex: one transfer per pixel, in the same order, giving the
// map entry index relative to the map base, the pixel position inside the
// 8x8 tile, and a transparent flag for texels outside the map with wrapping
// off or for columns beyond the screen width.
// Configuration channel i_cfg: register index and data, always ready; a
// write to an index beyond the register list is dropped. Write it only while
// no pixel is in flight.
// A pixel transfer reaches o_tex through three register stages (multiply,
// sum and shift, range test and index), each holding one pixel; while the
// receiver keeps up, one pixel is taken every cycle.
// When the receiver stalls, each stage holds its pixel and an empty stage
// still fills, so i_pix.ready drops only once all three stages are full.
// Reset empties the pipeline and loads the identity transform, a 128-pixel
// map and wrapping off.
module affine_background_texel_address
    import afbg_pkg::*;
#(
    parameter int SCREEN_WIDTH = 240
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    afbg_pix_if.sink   i_pix,
    afbg_tex_if.source o_tex,
    afbg_cfg_if.sink   i_cfg
);

    t_cfg      r_cfg;
    t_pipe_ctl ctl;
    logic      mul_valid;
    logic      sum_valid;
    logic      addr_valid;
    t_prod     prod;
    t_texel    texel;
    t_result   result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_x_col  <= RstStepXCol;
            r_cfg.step_x_line <= RstStepXLine;
            r_cfg.step_y_col  <= RstStepYCol;
            r_cfg.step_y_line <= RstStepYLine;
            r_cfg.origin_x    <= RstOrigin;
            r_cfg.origin_y    <= RstOrigin;
            r_cfg.size_sel    <= 2'd0;
            r_cfg.wrap_en     <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_STEP_X_COL:  r_cfg.step_x_col  <= i_cfg.data[StepW-1:0];
                REG_STEP_X_LINE: r_cfg.step_x_line <= i_cfg.data[StepW-1:0];
                REG_STEP_Y_COL:  r_cfg.step_y_col  <= i_cfg.data[StepW-1:0];
                REG_STEP_Y_LINE: r_cfg.step_y_line <= i_cfg.data[StepW-1:0];
                REG_ORIGIN_X:    r_cfg.origin_x    <= i_cfg.data[OriginW-1:0];
                REG_ORIGIN_Y:    r_cfg.origin_y    <= i_cfg.data[OriginW-1:0];
                REG_SIZE_SEL:    r_cfg.size_sel    <= i_cfg.data[1:0];
                REG_WRAP_EN:     r_cfg.wrap_en     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        ctl.adv_addr = !addr_valid || o_tex.ready;
        ctl.adv_sum  = !sum_valid || ctl.adv_addr;
        ctl.adv_mul  = !mul_valid || ctl.adv_sum;
    end

    assign i_pix.ready = ctl.adv_mul;

    afbg_mul_stage #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_mul (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (ctl.adv_mul),
        .i_valid     (i_pix.valid),
        .i_scan_line (i_pix.scan_line),
        .i_column    (i_pix.column),
        .i_cfg       (r_cfg),
        .o_valid     (mul_valid),
        .o_prod      (prod)
    );

    afbg_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (ctl.adv_sum),
        .i_valid (mul_valid),
        .i_prod  (prod),
        .i_cfg   (r_cfg),
        .o_valid (sum_valid),
        .o_texel (texel)
    );

    afbg_addr_stage u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (ctl.adv_addr),
        .i_valid  (sum_valid),
        .i_texel  (texel),
        .i_cfg    (r_cfg),
        .o_valid  (addr_valid),
        .o_result (result)
    );

    assign o_tex.valid       = addr_valid;
    assign o_tex.transparent = result.transparent;
    assign o_tex.map_index   = result.map_index;
    assign o_tex.texel_col   = result.texel_col;
    assign o_tex.texel_row   = result.texel_row;

endmodule

FILE: bench/tb_affine_background_texel_address.sv
module tb_affine_background_texel_address;
    import afbg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ScreenWidth = 240;
    localparam int RegCount    = 8;
    localparam int MinSide     = 128;
    localparam int MaxGap      = 7;
    localparam int DrainCycles = 8;
    localparam int CycleLimit  = 200000;
    localparam int MaxPrinted  = 50;
    localparam int RandomMaps  = 9;
    localparam int PixelsPerMap = 150;

    logic i_clk;
    logic i_rst_n;

    afbg_pix_if pix_ch ();
    afbg_tex_if tex_ch ();
    afbg_cfg_if cfg_ch ();

    affine_background_texel_address #(
        .SCREEN_WIDTH(ScreenWidth)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .o_tex  (tex_ch),
        .i_cfg  (cfg_ch)
    );

    t_cfg    map_cfg;
    t_result pending_texels[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    bit      pix_idle       = 1'b1;
    bit      tex_idle       = 1'b1;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_cfg default_map();
        t_cfg c;
        c.step_x_col  = RstStepXCol;
        c.step_x_line = RstStepXLine;
        c.step_y_col  = RstStepYCol;
        c.step_y_line = RstStepYLine;
        c.origin_x    = RstOrigin;
        c.origin_y    = RstOrigin;
        c.size_sel    = 2'd0;
        c.wrap_en     = 1'b0;
        return c;
    endfunction

    // Texel address for one pixel under the current map settings.
    function automatic t_result texel_for(input logic [PixW-1:0] scan,
                                          input logic [PixW-1:0] col);
        t_result r;
        longint  side;
        longint  ref_x;
        longint  ref_y;
        longint  tex_x;
        longint  tex_y;
        r = '0;
        r.transparent = 1'b1;
        if (int'(col) >= ScreenWidth) begin
            return r;
        end
        side  = longint'(MinSide) << map_cfg.size_sel;
        ref_x = longint'(map_cfg.origin_x) + longint'(scan) * longint'(map_cfg.step_x_line);
        ref_y = longint'(map_cfg.origin_y) + longint'(scan) * longint'(map_cfg.step_y_line);
        tex_x = (ref_x + longint'(col) * longint'(map_cfg.step_x_col)) >>> FracW;
        tex_y = (ref_y + longint'(col) * longint'(map_cfg.step_y_col)) >>> FracW;
        if (tex_x < 0 || tex_x >= side || tex_y < 0 || tex_y >= side) begin
            if (!map_cfg.wrap_en) begin
                return r;
            end
            // The side is a power of two, so wrapping keeps the low bits.
            tex_x = tex_x & (side - 1);
            tex_y = tex_y & (side - 1);
        end
        r.transparent = 1'b0;
        r.map_index   = IndexW'((tex_y >>> 3) * (side >>> 3) + (tex_x >>> 3));
        r.texel_col   = tex_x[2:0];
        r.texel_row   = tex_y[2:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MaxPrinted) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    // Tracks register writes, records each pixel transfer and checks each texel transfer.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            map_cfg = default_map();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_reg_idx'(cfg_ch.index))
                    REG_STEP_X_COL:  map_cfg.step_x_col  = cfg_ch.data[StepW-1:0];
                    REG_STEP_X_LINE: map_cfg.step_x_line = cfg_ch.data[StepW-1:0];
                    REG_STEP_Y_COL:  map_cfg.step_y_col  = cfg_ch.data[StepW-1:0];
                    REG_STEP_Y_LINE: map_cfg.step_y_line = cfg_ch.data[StepW-1:0];
                    REG_ORIGIN_X:    map_cfg.origin_x    = cfg_ch.data[OriginW-1:0];
                    REG_ORIGIN_Y:    map_cfg.origin_y    = cfg_ch.data[OriginW-1:0];
                    REG_SIZE_SEL:    map_cfg.size_sel    = cfg_ch.data[1:0];
                    REG_WRAP_EN:     map_cfg.wrap_en     = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (pix_ch.valid && pix_ch.ready) begin
                pending_texels.push_back(texel_for(pix_ch.scan_line, pix_ch.column));
            end
            if (tex_ch.valid && tex_ch.ready) begin
                if (pending_texels.size() == 0) begin
                    report_mismatch("texel with no pixel pending", tex_ch.map_index, 0);
                end else begin
                    want = pending_texels.pop_front();
                    if (tex_ch.transparent !== want.transparent)
                        report_mismatch("transparent", tex_ch.transparent, want.transparent);
                    if (tex_ch.map_index !== want.map_index)
                        report_mismatch("map_index", tex_ch.map_index, want.map_index);
                    if (tex_ch.texel_col !== want.texel_col)
                        report_mismatch("texel_col", tex_ch.texel_col, want.texel_col);
                    if (tex_ch.texel_row !== want.texel_row)
                        report_mismatch("texel_row", tex_ch.texel_row, want.texel_row);
                end
            end
        end
    end

    initial begin : texel_sink
        int unsigned stall;
        tex_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = tex_idle ? $urandom_range(0, MaxGap) : 0;
            if (stall != 0) begin
                tex_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            tex_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!tex_ch.valid);
        end
    end

    // Valid stays high after the write when more writes follow.
    task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgW-1:0] value,
                             input bit more);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (!more) begin
            cfg_ch.valid <= 1'b0;
        end
    endtask

    // Every register is written, the step, size and wrap registers with junk above their width, plus a dropped write.
    task automatic program_map(input t_cfg c);
        write_reg(RegIdxW'($urandom_range(RegCount, 255)), CfgW'($urandom), 1'b1);
        write_reg(REG_STEP_X_COL,  {12'($urandom), c.step_x_col},  1'b1);
        write_reg(REG_STEP_X_LINE, {12'($urandom), c.step_x_line}, 1'b1);
        write_reg(REG_STEP_Y_COL,  {12'($urandom), c.step_y_col},  1'b1);
        write_reg(REG_STEP_Y_LINE, {12'($urandom), c.step_y_line}, 1'b1);
        write_reg(REG_ORIGIN_X,    c.origin_x,                     1'b1);
        write_reg(REG_ORIGIN_Y,    c.origin_y,                     1'b1);
        write_reg(REG_SIZE_SEL,    {26'($urandom), c.size_sel},    1'b1);
        write_reg(REG_WRAP_EN,     {27'($urandom), c.wrap_en},     1'b0);
    endtask

    task automatic send_pixel(input logic [PixW-1:0] scan, input logic [PixW-1:0] col);
        int unsigned gap;
        gap = pix_idle ? $urandom_range(0, MaxGap) : 0;
        if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.scan_line <= scan;
        pix_ch.column    <= col;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    // Ends the pixel stream and waits for every texel to come back.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_texels.size() != 0);
    endtask

    task automatic test_reset_transform();
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd239);
        send_pixel(8'd0, 8'd240);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd127, 8'd127);
        send_pixel(8'd0, 8'd128);
        send_pixel(8'd128, 8'd0);
        wait_idle();
    endtask

    task automatic test_wrap_and_sizes();
        t_cfg c;
        c = default_map();
        c.wrap_en  = 1'b1;
        c.origin_x = -28'sd1;
        program_map(c);
        // A texel just left of the map wraps to its last column.
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd200, 8'd239);
        wait_idle();
        c = default_map();
        c.size_sel = 2'd3;
        program_map(c);
        send_pixel(8'd255, 8'd239);
        send_pixel(8'd255, 8'd0);
        wait_idle();
        c.size_sel = 2'd1;
        program_map(c);
        send_pixel(8'd130, 8'd200);
        send_pixel(8'd64, 8'd231);
        wait_idle();
        c.size_sel = 2'd2;
        program_map(c);
        send_pixel(8'd170, 8'd85);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        t_cfg c;
        c.step_x_col  = 16'sh7FFF;
        c.step_x_line = 16'sh8000;
        c.step_y_col  = 16'sh8000;
        c.step_y_line = 16'sh7FFF;
        c.origin_x    = 28'sh7FFFFFF;
        c.origin_y    = 28'sh8000000;
        c.size_sel    = 2'd3;
        c.wrap_en     = 1'b1;
        program_map(c);
        send_pixel(8'd255, 8'd239);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd1, 8'd1);
        wait_idle();
        c.step_x_col  = 16'sh8000;
        c.step_y_line = 16'sh8000;
        c.origin_x    = 28'sh8000000;
        c.origin_y    = 28'sh7FFFFFF;
        c.wrap_en     = 1'b0;
        program_map(c);
        send_pixel(8'd255, 8'd239);
        send_pixel(8'd0, 8'd0);
        wait_idle();
        // A write beyond the register list must leave the map untouched.
        write_reg(RegIdxW'(RegCount), CfgW'($urandom), 1'b0);
        send_pixel(8'd255, 8'd239);
        wait_idle();
    endtask

    task automatic test_random_maps();
        t_cfg        c;
        int          side;
        logic [PixW-1:0] scan;
        logic [PixW-1:0] col;
        for (int m = 0; m < RandomMaps; m++) begin
            pix_idle = (m % 4 == 0) || (m % 4 == 1);
            tex_idle = (m % 4 == 0) || (m % 4 == 2);
            c.size_sel = 2'($urandom_range(0, 3));
            c.wrap_en  = 1'($urandom);
            if (m % 3 != 0) begin
                // Gentle transforms that keep most texels on or near the map.
                side = MinSide << c.size_sel;
                c.step_x_col  = 16'($urandom_range(0, 1023) - 512);
                c.step_x_line = 16'($urandom_range(0, 1023) - 512);
                c.step_y_col  = 16'($urandom_range(0, 1023) - 512);
                c.step_y_line = 16'($urandom_range(0, 1023) - 512);
                c.origin_x    = 28'($urandom_range(0, side * 256 - 1));
                c.origin_y    = 28'($urandom_range(0, side * 256 - 1));
            end else begin
                c.step_x_col  = 16'($urandom);
                c.step_x_line = 16'($urandom);
                c.step_y_col  = 16'($urandom);
                c.step_y_line = 16'($urandom);
                c.origin_x    = 28'($urandom);
                c.origin_y    = 28'($urandom);
            end
            program_map(c);
            for (int n = 0; n < PixelsPerMap; n++) begin
                scan = PixW'($urandom_range(0, 255));
                if ($urandom_range(0, 15) == 0) begin
                    col = PixW'($urandom_range(ScreenWidth, 255));
                end else begin
                    col = PixW'($urandom_range(0, ScreenWidth - 1));
                end
                send_pixel(scan, col);
            end
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        pix_ch.valid     <= 1'b0;
        pix_ch.scan_line <= '0;
        pix_ch.column    <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_transform();
        test_wrap_and_sizes();
        test_register_extremes();
        test_random_maps();

        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/afbg_pkg.sv
sv/afbg_if.sv
sv/afbg_mul_stage.sv
sv/afbg_sum_stage.sv
sv/afbg_addr_stage.sv
sv/affine_background_texel_address.sv
bench/tb_affine_background_texel_address.sv
